/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared sizes, codes, types and helper functions of the thinning block.
// ----------------------------------------------------------------------------
package stt_pkg;

    // frame storage sizes
    localparam int MAX_COLS = 320;
    localparam int MAX_ROWS = 240;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int TOTAL_W  = $clog2(DEPTH + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);
    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int RIDX_W   = $clog2(MAX_ROWS);
    localparam int CIDX_W   = $clog2(MAX_COLS);

    // configuration register port
    localparam int CFG_COLS_W = 9;
    localparam int CFG_ROWS_W = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

    // pixel codes in the store
    localparam logic [1:0] PIX_BLACK = 2'd0;
    localparam logic [1:0] PIX_WHITE = 2'd1;
    localparam logic [1:0] PIX_MARK  = 2'd2;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic [7:0] PIX_OUT_WHITE = 8'd255;

    // scan phases
    localparam logic [2:0] PH_M1  = 3'd0;
    localparam logic [2:0] PH_M2  = 3'd1;
    localparam logic [2:0] PH_M3  = 3'd2;
    localparam logic [2:0] PH_M4  = 3'd3;
    localparam logic [2:0] PH_DEL = 3'd4;

    // neighbourhood slots: center, then E NE N NW W SW S SE
    localparam int NB_N   = 9;
    localparam int SLOT_C = 0;
    localparam int SLOT_E = 1;
    localparam int SLOT_N = 3;
    localparam int SLOT_W = 5;
    localparam int SLOT_S = 7;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       last_out;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [1:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] rows;
        logic [COL_W-1:0] cols;
    } t_eng_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    // linear store address of a pixel
    function automatic logic [ADDR_W-1:0] stt_addr(input logic [RIDX_W-1:0] row,
                                                   input logic [CIDX_W-1:0] col);
        stt_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS)) + ADDR_W'(col);
    endfunction

    // row offset of a neighbourhood slot, two's complement
    function automatic logic [1:0] nb_dr(input logic [3:0] slot);
        case (slot)
            4'd2, 4'd3, 4'd4: nb_dr = 2'b11;
            4'd6, 4'd7, 4'd8: nb_dr = 2'b01;
            default:          nb_dr = 2'b00;
        endcase
    endfunction

    // column offset of a neighbourhood slot, two's complement
    function automatic logic [1:0] nb_dc(input logic [3:0] slot);
        case (slot)
            4'd1, 4'd2, 4'd8: nb_dc = 2'b01;
            4'd4, 4'd5, 4'd6: nb_dc = 2'b11;
            default:          nb_dc = 2'b00;
        endcase
    endfunction

endpackage

/* src/stt_store.sv */
// ----------------------------------------------------------------------------
// stt_store
// Pixel store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_store
    import stt_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [1:0] o_rdata
);

    logic [1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* src/stt_engine.sv */
// ----------------------------------------------------------------------------
// stt_engine
// Thinning sequencer: reads each 3x3 neighbourhood from the store, marks,
// writes back, and runs the delete pass until a round changes nothing.
// ----------------------------------------------------------------------------
module stt_engine
    import stt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_eng_req   i_req,
    input  logic [1:0] i_rdata,
    output t_mem_req   o_mem,
    output t_eng_stat  o_stat
);

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_READ = 5'b00010,
        E_EVAL = 5'b00100,
        E_DRD  = 5'b01000,
        E_DWR  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [RIDX_W-1:0] r_row, n_row;
    logic [CIDX_W-1:0] r_col, n_col;
    logic [3:0]        r_step, n_step;
    logic              r_oob, n_oob;
    logic              r_changed, n_changed;
    logic [ROW_W-1:0]  r_rows;
    logic [COL_W-1:0]  r_cols;
    logic [1:0]        r_nb [NB_N];

    logic [1:0]        w_dr, w_dc;
    logic [ROW_W:0]    w_nr;
    logic [COL_W:0]    w_nc;
    logic              w_noob;
    logic              w_rl, w_cl, w_r0, w_c0;
    logic [RIDX_W-1:0] w_adv_row, w_rlast;
    logic [CIDX_W-1:0] w_adv_col, w_clast;
    logic              w_adv_end;
    logic              w_hold, w_mark;
    logic [3:0]        w_nblack;
    logic [2:0]        w_yokoi;
    logic [NB_N-1:0]   w_v;
    logic              w_end_phase;
    logic              w_del_hit;

    assign w_rlast = RIDX_W'(r_rows - 1'b1);
    assign w_clast = CIDX_W'(r_cols - 1'b1);
    assign w_rl = (r_row == w_rlast);
    assign w_cl = (r_col == w_clast);
    assign w_r0 = (r_row == '0);
    assign w_c0 = (r_col == '0);

    // neighbour coordinates and frame bounds
    assign w_dr = nb_dr(r_step);
    assign w_dc = nb_dc(r_step);
    assign w_nr = {1'b0, ROW_W'(r_row)} + {{(ROW_W - 1){w_dr[1]}}, w_dr};
    assign w_nc = {1'b0, COL_W'(r_col)} + {{(COL_W - 1){w_dc[1]}}, w_dc};
    assign w_noob = w_nr[ROW_W] || (w_nr[ROW_W-1:0] >= r_rows)
                 || w_nc[COL_W] || (w_nc[COL_W-1:0] >= r_cols);

    // next pixel in the scan order of the phase
    always_comb begin
        w_adv_row = r_row;
        w_adv_col = r_col;
        w_adv_end = 1'b0;
        case (r_phase)
            PH_M2: begin
                if (!w_r0) w_adv_row = r_row - 1'b1;
                else begin
                    w_adv_row = w_rlast;
                    if (!w_cl) w_adv_col = r_col + 1'b1;
                    else       w_adv_end = 1'b1;
                end
            end
            PH_M3: begin
                if (!w_c0) w_adv_col = r_col - 1'b1;
                else begin
                    w_adv_col = w_clast;
                    if (!w_r0) w_adv_row = r_row - 1'b1;
                    else       w_adv_end = 1'b1;
                end
            end
            PH_M4: begin
                if (!w_rl) w_adv_row = r_row + 1'b1;
                else begin
                    w_adv_row = '0;
                    if (!w_c0) w_adv_col = r_col - 1'b1;
                    else       w_adv_end = 1'b1;
                end
            end
            default: begin
                if (!w_cl) w_adv_col = r_col + 1'b1;
                else begin
                    w_adv_col = '0;
                    if (!w_rl) w_adv_row = r_row + 1'b1;
                    else       w_adv_end = 1'b1;
                end
            end
        endcase
    end

    // template, neighbour count and connectivity tests
    always_comb begin
        w_nblack = '0;
        for (int k = 0; k < NB_N; k++) begin
            w_v[k] = (r_nb[k] != PIX_BLACK);
        end
        for (int k = 1; k < NB_N; k++) begin
            if (r_nb[k] == PIX_BLACK) w_nblack = w_nblack + 1'b1;
        end
        w_yokoi = 3'(w_v[1] & ~(w_v[2] & w_v[3])) + 3'(w_v[3] & ~(w_v[4] & w_v[5]))
                + 3'(w_v[5] & ~(w_v[6] & w_v[7])) + 3'(w_v[7] & ~(w_v[8] & w_v[1]));
        case (r_phase)
            PH_M1:   w_hold = (r_nb[SLOT_N] == PIX_WHITE) && (r_nb[SLOT_S] != PIX_WHITE);
            PH_M2:   w_hold = (r_nb[SLOT_W] == PIX_WHITE) && (r_nb[SLOT_E] != PIX_WHITE);
            PH_M3:   w_hold = (r_nb[SLOT_N] != PIX_WHITE) && (r_nb[SLOT_S] == PIX_WHITE);
            default: w_hold = (r_nb[SLOT_W] != PIX_WHITE) && (r_nb[SLOT_E] == PIX_WHITE);
        endcase
        w_mark = (r_nb[SLOT_C] == PIX_BLACK) && w_hold && (w_nblack != 4'd1)
              && (w_yokoi == 3'd1);
    end

    assign w_del_hit = (r_state == E_DWR) && (i_rdata == PIX_MARK);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_row       = r_row;
        n_col       = r_col;
        n_step      = r_step;
        n_oob       = r_oob;
        n_changed   = r_changed;
        w_end_phase = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = stt_addr(r_row, r_col);
        o_mem.wdata = PIX_MARK;
        o_mem.raddr = stt_addr(r_row, r_col);
        o_stat.busy = (r_state != E_IDLE);
        o_stat.done = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_state   = E_READ;
                    n_phase   = PH_M1;
                    n_row     = '0;
                    n_col     = '0;
                    n_step    = '0;
                    n_changed = 1'b0;
                end
            end
            E_READ: begin
                o_mem.raddr = w_noob ? '0 :
                    stt_addr(w_nr[RIDX_W-1:0], w_nc[CIDX_W-1:0]);
                n_oob  = w_noob;
                n_step = r_step + 1'b1;
                if (r_step == 4'(NB_N)) begin
                    n_state = E_EVAL;
                end
            end
            E_EVAL: begin
                o_mem.we  = w_mark;
                n_step    = '0;
                n_row     = w_adv_row;
                n_col     = w_adv_col;
                n_state   = E_READ;
                w_end_phase = w_adv_end;
            end
            E_DRD: begin
                n_state = E_DWR;
            end
            E_DWR: begin
                o_mem.we    = w_del_hit;
                o_mem.wdata = PIX_WHITE;
                n_changed   = r_changed | w_del_hit;
                n_row       = w_adv_row;
                n_col       = w_adv_col;
                n_state     = E_DRD;
                w_end_phase = w_adv_end;
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase

        // phase change and round end
        if (w_end_phase) begin
            case (r_phase)
                PH_M1: begin
                    n_phase = PH_M2;
                    n_row   = w_rlast;
                    n_col   = '0;
                end
                PH_M2: begin
                    n_phase = PH_M3;
                    n_row   = w_rlast;
                    n_col   = w_clast;
                end
                PH_M3: begin
                    n_phase = PH_M4;
                    n_row   = '0;
                    n_col   = w_clast;
                end
                PH_M4: begin
                    n_phase = PH_DEL;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = E_DRD;
                end
                default: begin
                    n_row = '0;
                    n_col = '0;
                    if (n_changed) begin
                        n_phase   = PH_M1;
                        n_changed = 1'b0;
                        n_state   = E_READ;
                    end else begin
                        n_state     = E_IDLE;
                        o_stat.done = 1'b1;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= E_IDLE;
            r_phase   <= PH_M1;
            r_step    <= '0;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_changed <= n_changed;
        end
    end

    // position, frame size and neighbourhood capture
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_oob <= n_oob;
        if (r_state == E_IDLE && i_req.start) begin
            r_rows <= i_req.rows;
            r_cols <= i_req.cols;
        end
        if (r_state == E_READ && r_step != '0) begin
            r_nb[r_step - 1'b1] <= r_oob ? PIX_WHITE : i_rdata;
        end
    end

endmodule

/* src/stentiford_thinning_top.sv */
// ----------------------------------------------------------------------------
// stentiford_thinning_top
// Frame loader, thinning engine and pixel fetch around one pixel store.
// ----------------------------------------------------------------------------
// Command channel: an item transfers at a clock edge with i_start high and
// o_busy low. A load item (kind 0) writes the next pixel row-major; a fetch
// item (kind 1) reads the next thinned pixel once a frame is ready.
// Loads and fetches transfer one per cycle while o_busy is low. A fetch result
// shows on o_out with o_strobe for one cycle, in the cycle after the fetch
// transfers; the receiver takes it in that cycle and cannot hold it off.
// The load that completes the frame starts thinning; o_busy stays high
// until it finishes. Each round runs four template scans (per pixel, nine
// neighbourhood reads through the one store read port, then one evaluate
// and write) and a delete pass (per pixel, a read state and a write state).
// Rounds repeat until one deletes nothing.
// Configuration writes on the cfg channel are always taken (o_cfg_ready is
// high); each one holds o_busy high while the load position is re-derived
// from the load count with a serial divider.
// Reset clears the counters and control state; the store holds no contents
// that count until loaded.
// ----------------------------------------------------------------------------
module stentiford_thinning_top
    import stt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in                   i_in,
    output logic                  o_busy,
    output logic                  o_strobe,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DIV_STEPS = TOTAL_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    logic [CFG_COLS_W-1:0] r_cfg_cols;
    logic [CFG_ROWS_W-1:0] r_cfg_rows;
    logic [COL_W-1:0]      w_cols_u;
    logic [ROW_W-1:0]      w_rows_u;
    logic [TOTAL_W-1:0]    r_total;

    logic [TOTAL_W-1:0]    r_ld_idx, n_ld_idx;
    logic [RIDX_W-1:0]     r_ld_row;
    logic [CIDX_W-1:0]     r_ld_col;
    logic [RIDX_W-1:0]     r_rd_row;
    logic [CIDX_W-1:0]     r_rd_col;
    logic [ROW_W-1:0]      r_fr_rows;
    logic [COL_W-1:0]      r_fr_cols;
    logic                  r_frame_ready;
    logic                  r_fetch_v;
    logic                  r_fetch_last;

    logic                  r_div_busy;
    logic [DCNT_W-1:0]     r_div_cnt;
    logic [COL_W:0]        r_div_rem;
    logic [TOTAL_W-1:0]    r_div_quo;
    logic [COL_W:0]        w_div_sh;
    logic                  w_div_ge;

    logic                  w_take, w_load, w_fetch, w_store, w_go, w_rd_last;
    logic                  w_cfg_wr;
    t_mem_req              w_top_mem, w_eng_mem, w_mem;
    t_eng_req              w_eng_req;
    t_eng_stat             w_eng_stat;
    logic [1:0]            w_rdata;

    // clamped frame size from the registers
    always_comb begin
        if (r_cfg_cols == '0)                        w_cols_u = COL_W'(1);
        else if (r_cfg_cols > CFG_COLS_W'(MAX_COLS)) w_cols_u = COL_W'(MAX_COLS);
        else                                         w_cols_u = COL_W'(r_cfg_cols);
        if (r_cfg_rows == '0)                        w_rows_u = ROW_W'(1);
        else if (r_cfg_rows > CFG_ROWS_W'(MAX_ROWS)) w_rows_u = ROW_W'(MAX_ROWS);
        else                                         w_rows_u = ROW_W'(r_cfg_rows);
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    assign o_busy  = w_eng_stat.busy || r_div_busy;
    assign w_take  = i_start && !o_busy;
    assign w_load  = w_take && (i_in.kind == KIND_LOAD) && !r_frame_ready;
    assign w_fetch = w_take && (i_in.kind == KIND_FETCH) && r_frame_ready;
    assign w_store = w_load && (r_ld_idx < r_total);
    assign n_ld_idx = r_ld_idx + TOTAL_W'(w_store);
    assign w_go    = w_load && (n_ld_idx >= r_total);
    assign w_rd_last = (r_rd_row == RIDX_W'(r_fr_rows - 1'b1))
                    && (r_rd_col == CIDX_W'(r_fr_cols - 1'b1));

    // store access from the load and fetch side
    always_comb begin
        w_top_mem.we    = w_store;
        w_top_mem.waddr = stt_addr(r_ld_row, r_ld_col);
        w_top_mem.wdata = (i_in.pixel_in != '0) ? PIX_WHITE : PIX_BLACK;
        w_top_mem.raddr = stt_addr(r_rd_row, r_rd_col);
    end

    assign w_mem = w_eng_stat.busy ? w_eng_mem : w_top_mem;

    assign w_eng_req.start = w_go;
    assign w_eng_req.rows  = w_rows_u;
    assign w_eng_req.cols  = w_cols_u;

    stt_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    stt_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_eng_req),
        .i_rdata (w_rdata),
        .o_mem   (w_eng_mem),
        .o_stat  (w_eng_stat)
    );

    // serial divider step: load count over columns gives row and column
    assign w_div_sh = {r_div_rem[COL_W-1:0], r_div_quo[TOTAL_W-1]};
    assign w_div_ge = (w_div_sh >= (COL_W + 1)'(w_cols_u));

    // configuration registers and frame total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_COLS_W'(320);
            r_cfg_rows <= CFG_ROWS_W'(240);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_COLS: r_cfg_cols <= i_cfg_data;
                CFG_ROWS: r_cfg_rows <= i_cfg_data[CFG_ROWS_W-1:0];
                default:  ;
            endcase
        end
        r_total <= TOTAL_W'(TOTAL_W'(w_cols_u) * TOTAL_W'(w_rows_u));
    end

    // load position, divider and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_idx      <= '0;
            r_ld_row      <= '0;
            r_ld_col      <= '0;
            r_rd_row      <= '0;
            r_rd_col      <= '0;
            r_fr_rows     <= ROW_W'(1);
            r_fr_cols     <= COL_W'(1);
            r_frame_ready <= 1'b0;
            r_fetch_v     <= 1'b0;
            r_fetch_last  <= 1'b0;
            r_div_busy    <= 1'b0;
            r_div_cnt     <= '0;
        end else begin
            r_fetch_v    <= w_fetch;
            r_fetch_last <= w_fetch && w_rd_last;
            if (w_cfg_wr) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DCNT_W'(DIV_STEPS);
                r_div_rem  <= '0;
                r_div_quo  <= r_ld_idx;
            end else if (r_div_busy) begin
                if (r_div_cnt == '0) begin
                    r_div_busy <= 1'b0;
                    r_ld_row   <= r_div_quo[RIDX_W-1:0];
                    r_ld_col   <= r_div_rem[CIDX_W-1:0];
                end else begin
                    r_div_cnt <= r_div_cnt - 1'b1;
                    r_div_rem <= w_div_ge ? (w_div_sh - (COL_W + 1)'(w_cols_u)) : w_div_sh;
                    r_div_quo <= {r_div_quo[TOTAL_W-2:0], w_div_ge};
                end
            end
            if (w_go) begin
                r_ld_idx  <= '0;
                r_ld_row  <= '0;
                r_ld_col  <= '0;
                r_rd_row  <= '0;
                r_rd_col  <= '0;
                r_fr_rows <= w_rows_u;
                r_fr_cols <= w_cols_u;
            end else if (w_store) begin
                r_ld_idx <= n_ld_idx;
                if (COL_W'(r_ld_col) + 1'b1 == w_cols_u) begin
                    r_ld_col <= '0;
                    r_ld_row <= r_ld_row + 1'b1;
                end else begin
                    r_ld_col <= r_ld_col + 1'b1;
                end
            end
            if (w_eng_stat.done) begin
                r_frame_ready <= 1'b1;
            end
            if (w_fetch) begin
                if (w_rd_last) begin
                    r_frame_ready <= 1'b0;
                    r_rd_row      <= '0;
                    r_rd_col      <= '0;
                end else if (r_rd_col == CIDX_W'(r_fr_cols - 1'b1)) begin
                    r_rd_col <= '0;
                    r_rd_row <= r_rd_row + 1'b1;
                end else begin
                    r_rd_col <= r_rd_col + 1'b1;
                end
            end
        end
    end

    // fetch result, in the cycle after the transfer
    assign o_strobe        = r_fetch_v;
    assign o_out.out_pixel = (w_rdata == PIX_BLACK) ? 8'd0 : PIX_OUT_WHITE;
    assign o_out.last_out  = r_fetch_last;

endmodule

/* src/stt_checker.sv */
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the thinning block, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_in  i_in,
    input logic o_busy,
    input logic o_strobe,
    input t_out o_out
);

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // every result follows a fetch transfer
    a_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy && (i_in.kind == KIND_FETCH)))
        else $error("result without a fetch transfer");

    // results are black or white only
    a_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out.out_pixel == 8'd0 || o_out.out_pixel == PIX_OUT_WHITE))
        else $error("result pixel is not binary");

    // nothing follows the final pixel of a frame at once
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_out) |=> !o_strobe)
        else $error("result right after the frame end");

endmodule

bind stentiford_thinning_top stt_checker u_stt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_in     (i_in),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);

/* sim/stentiford_thinning_top_tb.sv */
// ----------------------------------------------------------------------------
// stentiford_thinning_top_tb
// Self-checking bench for the thinning block. Frames are loaded row-major,
// thinned by an in-bench predictor and fetched back. Every fetched pixel is
// compared with the predicted skeleton. Frame sizes cover the clamped
// extremes, a mid-load shrink, and ignored loads and fetches.
// ----------------------------------------------------------------------------
module stentiford_thinning_top_tb;
    import stt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_e;

    typedef struct {
        job_kind_e             kind;
        t_in                   item;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } job_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start_r     = 1'b0;
    t_in                   in_r        = '0;
    logic                  cfg_valid_r = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx_r   = '0;
    logic [CFG_DATA_W-1:0] cfg_data_r  = '0;
    logic                  o_busy;
    logic                  o_strobe;
    t_out                  o_out;
    logic                  o_cfg_ready;

    job_t job_q[$];
    t_out skel_q[$];
    int   err_cnt = 0;

    // predictor state
    logic [1:0] img [0:MAX_ROWS-1][0:MAX_COLS-1];
    int         cols_reg = 320;
    int         rows_reg = 240;
    int         fr_rows  = 1;
    int         fr_cols  = 1;
    int         load_idx = 0;
    int         read_idx = 0;
    logic       frame_rdy = 1'b0;

    stentiford_thinning_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_r),
        .i_in        (in_r),
        .o_busy      (o_busy),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid_r),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx_r),
        .i_cfg_data  (cfg_data_r)
    );

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // skeleton predictor
    // ------------------------------------------------------------------------
    function automatic logic [1:0] px_at(int r, int c);
        if (r < 0 || c < 0 || r >= fr_rows || c >= fr_cols) return PIX_WHITE;
        return img[r][c];
    endfunction

    function automatic int black_cnt(int r, int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if ((dr != 0 || dc != 0) && px_at(r + dr, c + dc) == PIX_BLACK) n++;
        return n;
    endfunction

    function automatic int yokoi_num(int r, int c);
        int v[9];
        int k;
        int a;
        int b;
        k = 0;
        v[0] = 0;
        v[1] = px_at(r, c + 1) != PIX_BLACK;
        v[2] = px_at(r - 1, c + 1) != PIX_BLACK;
        v[3] = px_at(r - 1, c) != PIX_BLACK;
        v[4] = px_at(r - 1, c - 1) != PIX_BLACK;
        v[5] = px_at(r, c - 1) != PIX_BLACK;
        v[6] = px_at(r + 1, c - 1) != PIX_BLACK;
        v[7] = px_at(r + 1, c) != PIX_BLACK;
        v[8] = px_at(r + 1, c + 1) != PIX_BLACK;
        for (int i = 1; i <= 7; i += 2) begin
            a = i + 1;
            b = (i + 2 > 8) ? i - 6 : i + 2;
            k += v[i] - v[i] * v[a] * v[b];
        end
        return k;
    endfunction

    task automatic try_mark(int r, int c, logic [2:0] ph);
        logic hold;
        if (img[r][c] != PIX_BLACK) return;
        case (ph)
            PH_M1: hold = px_at(r - 1, c) == PIX_WHITE && px_at(r + 1, c) != PIX_WHITE;
            PH_M2: hold = px_at(r, c - 1) == PIX_WHITE && px_at(r, c + 1) != PIX_WHITE;
            PH_M3: hold = px_at(r - 1, c) != PIX_WHITE && px_at(r + 1, c) == PIX_WHITE;
            default: hold = px_at(r, c - 1) != PIX_WHITE && px_at(r, c + 1) == PIX_WHITE;
        endcase
        if (hold && black_cnt(r, c) != 1 && yokoi_num(r, c) == 1) img[r][c] = PIX_MARK;
    endtask

    task automatic thin_frame();
        logic changed;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int i = 0; i < fr_rows; i++)
                for (int j = 0; j < fr_cols; j++) try_mark(i, j, PH_M1);
            for (int j = 0; j < fr_cols; j++)
                for (int i = fr_rows - 1; i >= 0; i--) try_mark(i, j, PH_M2);
            for (int i = fr_rows - 1; i >= 0; i--)
                for (int j = fr_cols - 1; j >= 0; j--) try_mark(i, j, PH_M3);
            for (int j = fr_cols - 1; j >= 0; j--)
                for (int i = 0; i < fr_rows; i++) try_mark(i, j, PH_M4);
            // delete pass
            for (int i = 0; i < fr_rows; i++)
                for (int j = 0; j < fr_cols; j++)
                    if (img[i][j] == PIX_MARK) begin
                        img[i][j] = PIX_WHITE;
                        changed   = 1'b1;
                    end
        end
    endtask

    function automatic int clamp(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic predict_item(t_in it);
        int   cu;
        int   ru;
        int   total;
        t_out res;
        if (it.kind == KIND_LOAD) begin
            cu    = clamp(cols_reg, MAX_COLS);
            ru    = clamp(rows_reg, MAX_ROWS);
            total = cu * ru;
            if (frame_rdy) return;
            if (load_idx < total) begin
                img[load_idx / cu][load_idx % cu] = (it.pixel_in != 0) ? PIX_WHITE : PIX_BLACK;
                load_idx++;
            end
            if (load_idx >= total) begin
                fr_rows = ru;
                fr_cols = cu;
                thin_frame();
                load_idx  = 0;
                read_idx  = 0;
                frame_rdy = 1'b1;
            end
        end else begin
            total = fr_cols * fr_rows;
            if (!frame_rdy) return;
            if (read_idx >= total) read_idx = total - 1;
            res.out_pixel = (img[read_idx / fr_cols][read_idx % fr_cols] == PIX_BLACK) ?
                            8'd0 : PIX_OUT_WHITE;
            res.last_out  = (read_idx + 1 == total);
            skel_q.push_back(res);
            if (res.last_out) begin
                frame_rdy = 1'b0;
                read_idx  = 0;
            end else begin
                read_idx++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: commands and register writes from the job queue
    // ------------------------------------------------------------------------
    logic nstart;
    logic ncfg;
    int   gap_cnt   = 0;
    int   drain_cnt = 0;
    job_t jb;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_r     <= 1'b0;
            cfg_valid_r <= 1'b0;
            gap_cnt     = 0;
            drain_cnt   = 0;
        end else begin
            nstart = start_r;
            ncfg   = cfg_valid_r;
            // command transfer
            if (start_r && !o_busy) begin
                predict_item(in_r);
                nstart = 1'b0;
            end
            // register transfer
            if (cfg_valid_r && o_cfg_ready) begin
                if (cfg_idx_r == CFG_COLS) cols_reg = cfg_data_r;
                else rows_reg = cfg_data_r[CFG_ROWS_W-1:0];
                ncfg = 1'b0;
            end
            // next job
            if (!nstart && !ncfg) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (job_q.size() > 0) begin
                    jb = job_q[0];
                    case (jb.kind)
                        JOB_ITEM: begin
                            in_r   <= jb.item;
                            nstart = 1'b1;
                            void'(job_q.pop_front());
                            if (job_q.size() > 150 && $urandom_range(0, 4) == 0)
                                gap_cnt = $urandom_range(1, 7);
                        end
                        JOB_CFG: begin
                            if (!o_busy) begin
                                cfg_idx_r  <= jb.idx;
                                cfg_data_r <= jb.data;
                                ncfg = 1'b1;
                                void'(job_q.pop_front());
                            end
                        end
                        default: begin
                            if (skel_q.size() == 0 && !o_busy) begin
                                if (drain_cnt >= 4) begin
                                    void'(job_q.pop_front());
                                    drain_cnt = 0;
                                end else begin
                                    drain_cnt++;
                                end
                            end else begin
                                drain_cnt = 0;
                            end
                        end
                    endcase
                end
            end
            start_r     <= nstart;
            cfg_valid_r <= ncfg;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------------
    t_out exp_px;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (skel_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h/%b", $time,
                         o_out.out_pixel, o_out.last_out);
                err_cnt++;
            end else begin
                exp_px = skel_q.pop_front();
                if (o_out.out_pixel !== exp_px.out_pixel) begin
                    $display("%0t: out_pixel expected %h actual %h", $time,
                             exp_px.out_pixel, o_out.out_pixel);
                    err_cnt++;
                end
                if (o_out.last_out !== exp_px.last_out) begin
                    $display("%0t: last_out expected %b actual %b", $time,
                             exp_px.last_out, o_out.last_out);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    int item_cnt = 0;

    task automatic push_item(logic kind, logic [7:0] pix);
        job_t j;
        j.kind          = JOB_ITEM;
        j.item.kind     = kind;
        j.item.pixel_in = pix;
        j.idx           = '0;
        j.data          = '0;
        job_q.push_back(j);
        item_cnt++;
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        job_t j;
        j.kind = JOB_CFG;
        j.item = '0;
        j.idx  = idx;
        j.data = CFG_DATA_W'(val);
        job_q.push_back(j);
    endtask

    task automatic push_drain();
        job_t j;
        j.kind = JOB_DRAIN;
        j.item = '0;
        j.idx  = '0;
        j.data = '0;
        job_q.push_back(j);
    endtask

    function automatic logic [7:0] white_px();
        return 8'($urandom_range(1, 255));
    endfunction

    // one random frame: set size, load, fetch, with some ignored items
    task automatic add_frame(int craw, int rraw);
        int cu;
        int ru;
        int style;
        int r0;
        int r1;
        int c0;
        int c1;
        logic blk;
        cu = clamp(craw, MAX_COLS);
        ru = clamp(rraw, MAX_ROWS);
        style = $urandom_range(0, 3);
        r0 = $urandom_range(0, ru - 1);
        r1 = $urandom_range(r0, ru - 1);
        c0 = $urandom_range(0, cu - 1);
        c1 = $urandom_range(c0, cu - 1);
        push_drain();
        push_cfg(CFG_COLS, craw);
        push_cfg(CFG_ROWS, rraw);
        for (int r = 0; r < ru; r++)
            for (int c = 0; c < cu; c++) begin
                case (style)
                    0: blk = 1'($urandom_range(0, 1));
                    1: blk = 1'b1;
                    default: blk = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^
                                   ($urandom_range(0, 15) == 0);
                endcase
                if ($urandom_range(0, 15) == 0) push_item(KIND_FETCH, white_px());
                push_item(KIND_LOAD, blk ? 8'd0 : white_px());
            end
        if ($urandom_range(0, 2) == 0) push_item(KIND_LOAD, 8'($urandom));
        for (int k = 0; k < cu * ru; k++) push_item(KIND_FETCH, 8'($urandom));
        if ($urandom_range(0, 3) == 0) push_item(KIND_FETCH, 8'($urandom));
    endtask

    initial begin
        // fetch with no frame ready
        push_item(KIND_FETCH, 8'hff);
        // 3x3 frame, pixel extremes, load while ready, fetch past the end
        push_drain();
        push_cfg(CFG_COLS, 3);
        push_cfg(CFG_ROWS, 3);
        for (int k = 0; k < 7; k++) push_item(KIND_LOAD, 8'd0);
        push_item(KIND_LOAD, 8'd255);
        push_item(KIND_LOAD, 8'd1);
        push_item(KIND_LOAD, 8'd0);
        for (int k = 0; k < 10; k++) push_item(KIND_FETCH, 8'h00);
        // zero sizes clamp to a single pixel
        push_drain();
        push_cfg(CFG_COLS, 0);
        push_cfg(CFG_ROWS, 0);
        push_item(KIND_LOAD, 8'd0);
        push_item(KIND_FETCH, 8'h00);
        // shrink during a load, past the new frame end
        push_drain();
        push_cfg(CFG_COLS, 3);
        push_cfg(CFG_ROWS, 3);
        push_item(KIND_LOAD, 8'd0);
        push_item(KIND_LOAD, 8'd128);
        for (int k = 0; k < 3; k++) push_item(KIND_LOAD, 8'd0);
        push_cfg(CFG_COLS, 2);
        push_cfg(CFG_ROWS, 2);
        push_item(KIND_LOAD, 8'd0);
        for (int k = 0; k < 4; k++) push_item(KIND_FETCH, 8'h00);

        // random frames, mostly small, with the size extremes once each
        item_cnt = 0;
        for (int f = 0; item_cnt < 1550; f++) begin
            if (f == 2) add_frame(511, 1);
            else if (f == 5) add_frame(0, 255);
            else add_frame($urandom_range(1, 10), $urandom_range(1, 10));
        end

        // wait for the queue to empty and every result to arrive
        while (!(job_q.size() == 0 && !start_r && !cfg_valid_r && skel_q.size() == 0))
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_cnt == 0 && skel_q.size() == 0) begin
            $display("stentiford_thinning_top_tb OK");
        end else begin
            $display("stentiford_thinning_top_tb NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("stentiford_thinning_top_tb NOT OK");
        $finish;
    end

endmodule
